>>> rtl/char_lcd_text_cursor_engine_assert.svh
// Assertion macros shared by the character LCD cursor engine modules
`ifndef CHAR_LCD_TEXT_CURSOR_ENGINE_ASSERT_SVH
`define CHAR_LCD_TEXT_CURSOR_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on clk, off while arst_n is low.
`define LCDT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while arst_n is low.
`define LCDT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lcdt_pkg.sv
// Types, constants and cursor functions for the character LCD cursor engine
`timescale 1ns / 1ps

package lcdt_pkg;

	localparam int COLUMNS = 16;
	localparam int ROWS    = 2;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int IDX_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	// bundle queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic [7:0] ROW1_ADDR    = 8'h40;
	localparam logic [7:0] CHAR_UNKNOWN = 8'h3F;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] CTRL_LIMIT   = 8'h20;
	localparam logic [7:0] HDC_RESET    = 8'd127;

	typedef enum logic [1:0] {
		FUNC_WRITE,
		FUNC_MOVE,
		FUNC_SET_POS,
		FUNC_CLEAR
	} func_t;

	typedef enum logic [2:0] {
		MOVE_RIGHT,
		MOVE_LEFT,
		MOVE_UP,
		MOVE_DOWN,
		MOVE_ROW_END,
		MOVE_ROW_START,
		MOVE_TOP,
		MOVE_BOTTOM
	} move_t;

	typedef logic [IDX_W-1:0] idx_t;

	localparam idx_t IDX_LAST      = IDX_W'(CELLS - 1);
	localparam idx_t IDX_COLS      = IDX_W'(COLUMNS % CELLS);
	localparam idx_t IDX_ROW0_END  = IDX_W'(COLUMNS - 1);
	localparam idx_t LAST_ROW_BASE = IDX_W'((ROWS - 1) * COLUMNS);

	typedef struct packed {
		logic       is_data;
		logic [7:0] lcd_byte;
	} lcd_ent_t;

	// all controller bytes caused by one input item, cnt is 1 to 3
	typedef struct packed {
		logic [1:0]     cnt;
		lcd_ent_t [2:0] ent;
	} bundle_t;

	typedef struct packed {
		idx_t idx;
		logic clr;
	} move_res_t;

	function automatic logic row_of(idx_t idx);
		return (int'(idx) >= COLUMNS) && (ROWS > 1);
	endfunction

	function automatic logic [COL_W-1:0] col_of(idx_t idx);
		return row_of(idx) ? COL_W'(idx - IDX_COLS) : COL_W'(idx);
	endfunction

	function automatic logic [7:0] addr_byte(idx_t idx);
		logic [7:0] a;
		a = CMD_SET_ADDR | 8'(col_of(idx));
		if (row_of(idx)) begin
			a = a | ROW1_ADDR;
		end
		return a;
	endfunction

	// fold accented Latin-1 letters to plain ASCII, anything else to '?'
	function automatic logic [7:0] fold_char(logic [7:0] c);
		logic [7:0] base;
		logic [7:0] letter;
		logic       known;
		base   = c & 8'hDF;
		letter = 8'h41;
		known  = 1'b1;
		if (c < 8'hC0) begin
			known = 1'b0;
		end else if (base <= 8'hC4) begin
			letter = 8'h41;
		end else if (base == 8'hC7) begin
			letter = 8'h43;
		end else if (base >= 8'hC8 && base <= 8'hCB) begin
			letter = 8'h45;
		end else if (base >= 8'hCC && base <= 8'hCF) begin
			letter = 8'h49;
		end else if (base >= 8'hD2 && base <= 8'hD6) begin
			letter = 8'h4F;
		end else if (base >= 8'hD9 && base <= 8'hDC) begin
			letter = 8'h55;
		end else begin
			known = 1'b0;
		end
		if (!known) begin
			return CHAR_UNKNOWN;
		end
		return c[5] ? (letter + 8'h20) : letter;
	endfunction

	function automatic move_res_t move_cursor(idx_t idx, move_t kind);
		move_res_t r;
		idx_t      col_ext;
		logic      row;
		row     = row_of(idx);
		col_ext = idx_t'(col_of(idx));
		r.idx   = idx;
		r.clr   = 1'b0;
		unique case (kind)
			MOVE_RIGHT:     r.idx = (idx >= IDX_LAST) ? '0 : idx + idx_t'(1);
			MOVE_LEFT:      r.idx = (idx == '0) ? IDX_LAST : idx - idx_t'(1);
			MOVE_UP: begin
				if (!row) begin
					r.idx = LAST_ROW_BASE + col_ext;
					r.clr = 1'b1;
				end else begin
					r.idx = idx - IDX_COLS;
				end
			end
			MOVE_DOWN: begin
				if (int'(row) >= ROWS - 1) begin
					r.idx = col_ext;
					r.clr = 1'b1;
				end else begin
					r.idx = idx + IDX_COLS;
				end
			end
			MOVE_ROW_END:   r.idx = row ? IDX_LAST : IDX_ROW0_END;
			MOVE_ROW_START: r.idx = row ? IDX_COLS : '0;
			MOVE_TOP:       r.idx = col_ext;
			MOVE_BOTTOM:    r.idx = LAST_ROW_BASE + col_ext;
			default:        r.idx = idx;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/lcdt_front.sv
// Front end: accepts items, tracks the cursor and builds the byte bundle per item
`timescale 1ns / 1ps

module lcdt_front
	import lcdt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [1:0]  func,
	input  logic [7:0]  char_code,
	input  logic [2:0]  move_kind,
	input  logic [5:0]  target_column,
	input  logic [1:0]  target_row,
	input  logic        cfg_write,
	input  logic [7:0]  cfg_data,
	input  logic        q_full,
	output logic        q_push,
	output bundle_t     q_data
);

	`include "char_lcd_text_cursor_engine_assert.svh"

	logic      accept;
	idx_t      cursor_q;
	logic      cp_q;
	logic [7:0] hdc_q;
	idx_t      nidx;
	logic      ncp;
	move_t     mv_kind;
	move_res_t mv;
	logic      printable;
	logic      row_chg;
	logic [7:0] out_char;
	lcd_ent_t  data_ent;
	lcd_ent_t  addr_ent;
	lcd_ent_t  clr_ent;
	bundle_t   b;

	assign accept    = push && !q_full;
	assign printable = (char_code >= CTRL_LIMIT);
	assign out_char  = (char_code <= hdc_q) ? char_code : fold_char(char_code);

	// newline and carriage return reuse the move unit
	always_comb begin
		mv_kind = move_t'(move_kind);
		if (func_t'(func) == FUNC_WRITE) begin
			if (printable) begin
				mv_kind = MOVE_RIGHT;
			end else if (char_code == CHAR_CR) begin
				mv_kind = MOVE_ROW_START;
			end else begin
				mv_kind = MOVE_DOWN;
			end
		end
	end

	assign mv       = move_cursor(cursor_q, mv_kind);
	assign row_chg  = row_of(mv.idx) != row_of(cursor_q);
	assign data_ent = '{is_data: 1'b1, lcd_byte: out_char};
	assign addr_ent = '{is_data: 1'b0, lcd_byte: addr_byte(mv.idx)};
	assign clr_ent  = '{is_data: 1'b0, lcd_byte: CMD_CLEAR};

	always_comb begin
		b    = '0;
		nidx = cursor_q;
		ncp  = cp_q;
		unique case (func_t'(func))
			FUNC_WRITE: begin
				if (printable) begin
					nidx = mv.idx;
					ncp  = 1'b0;
					if (cp_q) begin
						b.ent[0] = clr_ent;
						b.ent[1] = data_ent;
						b.ent[2] = addr_ent;
						b.cnt    = row_chg ? 2'd3 : 2'd2;
					end else begin
						b.ent[0] = data_ent;
						b.ent[1] = addr_ent;
						b.cnt    = row_chg ? 2'd2 : 2'd1;
					end
				end else if (char_code == CHAR_NEWLINE || char_code == CHAR_CR) begin
					nidx     = mv.idx;
					ncp      = cp_q | mv.clr;
					b.ent[0] = addr_ent;
					b.cnt    = 2'd1;
				end
			end
			FUNC_MOVE: begin
				nidx     = mv.idx;
				ncp      = cp_q | mv.clr;
				b.ent[0] = addr_ent;
				b.cnt    = 2'd1;
			end
			FUNC_SET_POS: begin
				if (int'(target_column) < COLUMNS && int'(target_row) < ROWS) begin
					nidx     = idx_t'(int'(target_column) + int'(target_row) * COLUMNS);
					b.ent[0] = '{is_data: 1'b0, lcd_byte: addr_byte(nidx)};
					b.cnt    = 2'd1;
				end
			end
			FUNC_CLEAR: begin
				nidx     = '0;
				b.ent[0] = clr_ent;
				b.cnt    = 2'd1;
			end
			default: begin
				nidx = cursor_q;
			end
		endcase
	end

	// items that cause no byte never enter the queue
	assign q_push = accept && (b.cnt != 2'd0);
	assign q_data = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			cp_q     <= 1'b0;
			hdc_q    <= HDC_RESET;
		end else begin
			if (accept) begin
				cursor_q <= nidx;
				cp_q     <= ncp;
			end
			if (cfg_write) begin
				hdc_q <= cfg_data;
			end
		end
	end

	`LCDT_ASSERT_IMP(a_cp_drops_on_write, $fell(cp_q),
		$past(accept) && $past(func) == FUNC_WRITE, "clear_pending dropped without a write")
	`LCDT_ASSERT_IMP(a_three_lead_clear, q_push && q_data.cnt == 2'd3,
		q_data.ent[0].lcd_byte == CMD_CLEAR, "three-byte bundle does not open with clear")

endmodule

>>> rtl/lcdt_queue.sv
// Short bundle queue that decouples the front end from the byte sender
`timescale 1ns / 1ps

module lcdt_queue
	import lcdt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  bundle_t wdata,
	output logic    full,
	input  logic    rd,
	output logic    q_empty,
	output bundle_t rdata
);

	`include "char_lcd_text_cursor_engine_assert.svh"

	bundle_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign q_empty = (count_q == '0);
	assign rdata   = mem_q[rd_ptr_q];
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !q_empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`LCDT_ASSERT_IMP(a_no_write_when_full, wr, !full, "bundle written into a full queue")
	`LCDT_ASSERT_NXT(a_count_grows, do_wr && !do_rd, count_q == $past(count_q) + 1'b1,
		"queue count did not grow on a lone write")

endmodule

>>> rtl/lcdt_back.sv
// Back end: sends the bytes of each bundle, one transaction per cycle while pop is high
`timescale 1ns / 1ps

module lcdt_back
	import lcdt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  bundle_t    q_data,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic       is_data,
	output logic [7:0] lcd_byte,
	output logic       last
);

	`include "char_lcd_text_cursor_engine_assert.svh"

	bundle_t    cur_q;
	logic [1:0] pos_q;
	logic       cur_v_q;
	logic       done;
	lcd_ent_t   ent;

	assign ent      = cur_q.ent[pos_q];
	assign empty    = !cur_v_q;
	assign is_data  = ent.is_data;
	assign lcd_byte = ent.lcd_byte;
	assign last     = (pos_q == cur_q.cnt - 2'd1);

	// load the next bundle as the current one finishes, with no bubble
	assign done  = !cur_v_q || (pop && last);
	assign q_pop = done && !q_empty;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			pos_q   <= '0;
		end else if (q_pop) begin
			cur_v_q <= 1'b1;
			pos_q   <= '0;
		end else if (done) begin
			cur_v_q <= 1'b0;
		end else if (pop) begin
			pos_q <= pos_q + 2'd1;
		end
	end

	`LCDT_ASSERT_NXT(a_bundle_continues, pop && !empty && !last, !empty,
		"bundle ended before its last byte")

endmodule

>>> rtl/char_lcd_text_cursor_engine.sv
// Top level of the character LCD text and cursor engine
//
// Input side is a queue write port: an item (func, char_code, move_kind,
// target_column, target_row) is taken on a clock edge with push high and
// full low. The result side is a queue read port: while empty is low the
// oldest byte sits on is_data / lcd_byte / last, and it is taken on an edge
// with pop high. last marks the final byte of an item; items that cause no
// byte (ignored control codes, out-of-range set position) give nothing.
// An item's first byte reaches the ports after its bundle has been written
// into the bundle queue and then loaded into the back end. Each item yields
// at most three bytes (clear pending, character, address set), and the port
// moves one byte per cycle while pop is high. A two-entry bundle queue
// sits between the front end and the byte sender, so new items keep coming
// in while earlier bytes drain. When pop stays low the queue fills and full
// rises. cfg_write loads highest_direct_code at once; write it only while
// idle. Reset (arst_n low) puts the cursor at cell 0, clears the pending
// clear flag, sets highest_direct_code to 127 and empties the queue.
`timescale 1ns / 1ps

module char_lcd_text_cursor_engine
	import lcdt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] func,
	input  logic [7:0] char_code,
	input  logic [2:0] move_kind,
	input  logic [5:0] target_column,
	input  logic [1:0] target_row,
	input  logic       cfg_write,
	input  logic [7:0] cfg_data,
	output logic       empty,
	input  logic       pop,
	output logic       is_data,
	output logic [7:0] lcd_byte,
	output logic       last
);

	logic    q_push;
	bundle_t q_wdata;
	logic    q_full;
	logic    q_pop;
	logic    q_empty;
	bundle_t q_rdata;

	assign full = q_full;

	lcdt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.func          (func),
		.char_code     (char_code),
		.move_kind     (move_kind),
		.target_column (target_column),
		.target_row    (target_row),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (q_wdata)
	);

	lcdt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wdata   (q_wdata),
		.full    (q_full),
		.rd      (q_pop),
		.q_empty (q_empty),
		.rdata   (q_rdata)
	);

	lcdt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.is_data  (is_data),
		.lcd_byte (lcd_byte),
		.last     (last)
	);

endmodule

>>> bench/testbench.sv
// Self-checking bench for the character LCD text and cursor engine
`timescale 1ns / 1ps

module testbench;
	import lcdt_pkg::*;

	localparam int DRAIN_GAP = 8;

	typedef struct packed {
		logic       rs;
		logic [7:0] val;
		logic       fin;
	} lcd_out_t;

	typedef struct packed {
		func_t      fn;
		logic [7:0] code;
		move_t      kind;
		logic [5:0] col;
		logic [1:0] row;
		logic       typed;
		logic       typed_rs;
		logic [7:0] typed_val;
	} stim_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [1:0] func = '0;
	logic [7:0] char_code = '0;
	logic [2:0] move_kind = '0;
	logic [5:0] target_column = '0;
	logic [1:0] target_row = '0;
	logic       cfg_write = 1'b0;
	logic [7:0] cfg_data = '0;
	logic       empty;
	logic       pop = 1'b0;
	logic       is_data;
	logic [7:0] lcd_byte;
	logic       last;

	// predictor state
	int         cur_pos = 0;
	bit         clr_due = 1'b0;
	logic [7:0] direct_max = HDC_RESET;

	lcd_out_t   pending_bytes_q [$];
	lcd_out_t   new_bytes_q [$];
	stim_t      directed_q [$];

	bit         calm = 1'b0;
	int         err_cnt = 0;
	int         items_sent = 0;
	int         items_useful = 0;
	int         bytes_checked = 0;
	logic [7:0] mid_limit;

	char_lcd_text_cursor_engine u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.char_code    (char_code),
		.move_kind    (move_kind),
		.target_column(target_column),
		.target_row   (target_row),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.empty        (empty),
		.pop          (pop),
		.is_data      (is_data),
		.lcd_byte     (lcd_byte),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [7:0] ddram_set(int p);
		return CMD_SET_ADDR | 8'(p % COLUMNS) | ((p / COLUMNS == 1) ? ROW1_ADDR : 8'h00);
	endfunction

	function automatic logic [7:0] plain_letter(logic [7:0] c);
		logic [7:0] letter;
		if (c < 8'hC0) begin
			return CHAR_UNKNOWN;
		end
		case (c & 8'hDF)
			8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4: letter = "A";
			8'hC7: letter = "C";
			8'hC8, 8'hC9, 8'hCA, 8'hCB: letter = "E";
			8'hCC, 8'hCD, 8'hCE, 8'hCF: letter = "I";
			8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6: letter = "O";
			8'hD9, 8'hDA, 8'hDB, 8'hDC: letter = "U";
			default: return CHAR_UNKNOWN;
		endcase
		// lowercase variants sit 0x20 above
		return c[5] ? letter + 8'h20 : letter;
	endfunction

	// new cursor position; vertical wrap marks a clear for the next character
	function automatic int step_cursor(int p, move_t kind);
		int r;
		int c;
		r = p / COLUMNS;
		c = p % COLUMNS;
		case (kind)
			MOVE_RIGHT:     return (p >= CELLS - 1) ? 0 : p + 1;
			MOVE_LEFT:      return (p == 0) ? CELLS - 1 : p - 1;
			MOVE_UP: begin
				if (r == 0) begin
					clr_due = 1'b1;
					return (ROWS - 1) * COLUMNS + c;
				end
				return p - COLUMNS;
			end
			MOVE_DOWN: begin
				if (r >= ROWS - 1) begin
					clr_due = 1'b1;
					return c;
				end
				return p + COLUMNS;
			end
			MOVE_ROW_END:   return (r + 1) * COLUMNS - 1;
			MOVE_ROW_START: return r * COLUMNS;
			MOVE_TOP:       return c;
			default:        return (ROWS - 1) * COLUMNS + c;
		endcase
	endfunction

	// fill new_bytes_q with the bytes one transaction causes
	function automatic void predict_lcd_bytes(stim_t s);
		int prev_row;
		new_bytes_q.delete();
		case (s.fn)
			FUNC_WRITE: begin
				if (s.code < CTRL_LIMIT) begin
					if (s.code == CHAR_NEWLINE) begin
						cur_pos = step_cursor(cur_pos, MOVE_DOWN);
						new_bytes_q.push_back('{1'b0, ddram_set(cur_pos), 1'b0});
					end else if (s.code == CHAR_CR) begin
						cur_pos = step_cursor(cur_pos, MOVE_ROW_START);
						new_bytes_q.push_back('{1'b0, ddram_set(cur_pos), 1'b0});
					end
				end else begin
					prev_row = cur_pos / COLUMNS;
					if (clr_due) begin
						new_bytes_q.push_back('{1'b0, CMD_CLEAR, 1'b0});
						clr_due = 1'b0;
					end
					new_bytes_q.push_back('{1'b1,
						(s.code <= direct_max) ? s.code : plain_letter(s.code), 1'b0});
					cur_pos = step_cursor(cur_pos, MOVE_RIGHT);
					if (cur_pos / COLUMNS != prev_row) begin
						new_bytes_q.push_back('{1'b0, ddram_set(cur_pos), 1'b0});
					end
				end
			end
			FUNC_MOVE: begin
				cur_pos = step_cursor(cur_pos, s.kind);
				new_bytes_q.push_back('{1'b0, ddram_set(cur_pos), 1'b0});
			end
			FUNC_SET_POS: begin
				if (s.col < COLUMNS && s.row < ROWS) begin
					cur_pos = s.col + s.row * COLUMNS;
					new_bytes_q.push_back('{1'b0, ddram_set(cur_pos), 1'b0});
				end
			end
			default: begin
				new_bytes_q.push_back('{1'b0, CMD_CLEAR, 1'b0});
				cur_pos = 0;
			end
		endcase
		if (new_bytes_q.size() > 0) begin
			new_bytes_q[new_bytes_q.size() - 1].fin = 1'b1;
		end
	endfunction

	function automatic stim_t mk_stim(func_t fn, int code, move_t kind, int c, int r,
			bit typed = 1'b0, bit rs = 1'b0, int val = 0);
		stim_t s;
		s.fn        = fn;
		s.code      = 8'(code);
		s.kind      = kind;
		s.col       = 6'(c);
		s.row       = 2'(r);
		s.typed     = typed;
		s.typed_rs  = rs;
		s.typed_val = 8'(val);
		return s;
	endfunction

	function automatic stim_t rand_stim();
		stim_t s;
		int    pick;
		s = mk_stim(func_t'($urandom_range(3)), $urandom_range(255),
			move_t'($urandom_range(7)), $urandom_range(63), $urandom_range(3));
		pick = $urandom_range(99);
		if (pick < 45) begin
			s.fn   = FUNC_WRITE;
			s.code = ($urandom_range(1) != 0) ? 8'($urandom_range(8'h7E, 8'h20))
				: 8'($urandom_range(8'hFF, 8'h80));
		end else if (pick < 55) begin
			s.fn = FUNC_WRITE;
			case ($urandom_range(2))
				0: s.code = CHAR_NEWLINE;
				1: s.code = CHAR_CR;
				default: s.code = 8'($urandom_range(8'h1F));
			endcase
		end else if (pick < 75) begin
			s.fn = FUNC_MOVE;
		end else if (pick < 92) begin
			s.fn = FUNC_SET_POS;
			// mostly legal cells, the rest keeps the full field range
			if ($urandom_range(3) != 0) begin
				s.col = 6'($urandom_range(COLUMNS - 1));
				s.row = 2'($urandom_range(ROWS - 1));
			end
		end else begin
			s.fn = FUNC_CLEAR;
		end
		return s;
	endfunction

	task automatic send_item(input stim_t s, output int n);
		while (!calm && $urandom_range(99) < 34) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push          <= 1'b1;
		func          <= s.fn;
		char_code     <= s.code;
		move_kind     <= s.kind;
		target_column <= s.col;
		target_row    <= s.row;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		// transaction accepted at this edge
		predict_lcd_bytes(s);
		n = new_bytes_q.size();
		if (s.typed) begin
			pending_bytes_q.push_back('{s.typed_rs, s.typed_val, 1'b1});
		end else begin
			foreach (new_bytes_q[i]) begin
				pending_bytes_q.push_back(new_bytes_q[i]);
			end
		end
		items_sent++;
		if (n > 0) begin
			items_useful++;
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_bytes_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		wait_drained();
		cfg_write <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		cfg_write  <= 1'b0;
		direct_max  = v;
	endtask

	task automatic run_random(input int n_useful, input bit pause_mid);
		int    useful;
		int    n;
		bit    paused;
		stim_t s;
		useful = 0;
		paused = 1'b0;
		while (useful < n_useful) begin
			s = rand_stim();
			send_item(s, n);
			if (n > 0) begin
				useful++;
			end
			if (pause_mid && !paused && useful == n_useful / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	// check each popped byte against the oldest expectation
	always @(posedge clk) begin
		lcd_out_t want;
		if (arst_n && pop && !empty) begin
			if (pending_bytes_q.size() == 0) begin
				$error("unexpected byte: is_data %0b lcd_byte %02h last %0b",
					is_data, lcd_byte, last);
				err_cnt++;
			end else begin
				want = pending_bytes_q.pop_front();
				bytes_checked++;
				if (is_data !== want.rs) begin
					$error("is_data: expected %0b, got %0b", want.rs, is_data);
					err_cnt++;
				end
				if (lcd_byte !== want.val) begin
					$error("lcd_byte: expected %02h, got %02h", want.val, lcd_byte);
					err_cnt++;
				end
				if (last !== want.fin) begin
					$error("last: expected %0b, got %0b", want.fin, last);
					err_cnt++;
				end
			end
		end
		pop <= calm || ($urandom_range(99) >= 34);
	end

	initial begin
		int n;
		directed_q.push_back(mk_stim(FUNC_WRITE, "A", MOVE_RIGHT, 0, 0, 1'b1, 1'b1, 8'h41));
		directed_q.push_back(mk_stim(FUNC_CLEAR, 0, MOVE_RIGHT, 0, 0, 1'b1, 1'b0, 8'h01));
		directed_q.push_back(mk_stim(FUNC_SET_POS, 0, MOVE_RIGHT, 15, 1, 1'b1, 1'b0, 8'hCF));
		// highest direct code on the last cell: wraps to cell 0
		directed_q.push_back(mk_stim(FUNC_WRITE, 8'h7F, MOVE_RIGHT, 0, 0));
		// set position out of range
		directed_q.push_back(mk_stim(FUNC_SET_POS, 0, MOVE_RIGHT, COLUMNS, 0));
		directed_q.push_back(mk_stim(FUNC_SET_POS, 0, MOVE_RIGHT, 0, ROWS));
		directed_q.push_back(mk_stim(FUNC_SET_POS, 0, MOVE_RIGHT, 63, 3));
		// ignored control codes, then newline and carriage return
		directed_q.push_back(mk_stim(FUNC_WRITE, 8'h00, MOVE_RIGHT, 0, 0));
		directed_q.push_back(mk_stim(FUNC_WRITE, 8'h1F, MOVE_RIGHT, 0, 0));
		directed_q.push_back(mk_stim(FUNC_WRITE, CHAR_NEWLINE, MOVE_RIGHT, 0, 0));
		directed_q.push_back(mk_stim(FUNC_WRITE, CHAR_CR, MOVE_RIGHT, 0, 0));
		for (int k = 0; k < 8; k++) begin
			directed_q.push_back(mk_stim(FUNC_MOVE, 0, move_t'(k), 0, 0));
		end
		// wrap up from row 0, then a write at row end: clear, data, address
		directed_q.push_back(mk_stim(FUNC_SET_POS, 0, MOVE_RIGHT, 15, 0));
		directed_q.push_back(mk_stim(FUNC_MOVE, 0, MOVE_UP, 0, 0));
		directed_q.push_back(mk_stim(FUNC_MOVE, 0, MOVE_TOP, 0, 0));
		directed_q.push_back(mk_stim(FUNC_WRITE, "z", MOVE_RIGHT, 0, 0));
		// accented letters fold, others above the limit become '?'
		directed_q.push_back(mk_stim(FUNC_WRITE, 8'hE9, MOVE_RIGHT, 0, 0));
		directed_q.push_back(mk_stim(FUNC_WRITE, 8'hC0, MOVE_RIGHT, 0, 0));
		directed_q.push_back(mk_stim(FUNC_WRITE, 8'hFF, MOVE_RIGHT, 0, 0));
		directed_q.push_back(mk_stim(FUNC_WRITE, 8'hD7, MOVE_RIGHT, 0, 0));
		directed_q.push_back(mk_stim(FUNC_WRITE, 8'h80, MOVE_RIGHT, 0, 0));
		directed_q.push_back(mk_stim(FUNC_WRITE, 8'h20, MOVE_RIGHT, 0, 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i]) begin
			send_item(directed_q[i], n);
		end

		write_limit(8'd255);
		run_random(48, 1'b1);

		write_limit(8'd127);
		calm = 1'b1;
		run_random(48, 1'b0);
		calm = 1'b0;

		mid_limit = 8'($urandom_range(254, 128));
		write_limit(mid_limit);
		run_random(48, 1'b0);

		wait_drained();
		$display("Sent %0d transactions (%0d with output), checked %0d LCD bytes",
			items_sent, items_useful, bytes_checked);
		$display("Direct code limits 127, 255 and %0d; all moves, clears and folds",
			mid_limit);
		if (err_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
